// File: rtl/abso_pkg.sv
// shared constants, types and arithmetic helpers for the source-over blender
package abso_pkg;

  localparam int NCH  = 3;    // color channels per pixel (blue, green, red)
  localparam int CW   = 8;    // bits per channel
  localparam int PW   = 32;   // bits per pixel

  // pipeline stage numbering
  localparam int S_PRE  = 1;  // first premultiply stage (two stages)
  localparam int S_MIX  = 3;  // first combine stage (three stages)
  localparam int S_DIV  = 6;  // first divide stage (three stages)
  localparam int S_OUT  = 9;  // output register
  localparam int NSTG   = 10;

  localparam logic [CW-1:0] A_CLEAR  = 8'h00;
  localparam logic [CW-1:0] A_OPAQUE = 8'hFF;
  localparam logic [CW-1:0] C_MAX    = 8'd255;
  localparam logic [15:0]   RND      = 16'd127;

  localparam logic MODE_COPY = 1'b0;
  localparam logic MODE_OVER = 1'b1;

  typedef logic [CW-1:0] chan_t;
  typedef logic [15:0]   prod_t;   // c*a + 127, at most 65152
  typedef logic [8:0]    sum_t;    // premultiplied sum, at most 510
  typedef logic [16:0]   num_t;    // p*255 + oa/2, below 2^17

  // bypass decision that rides along the pipeline
  typedef struct packed {
    logic          byp;
    logic [PW-1:0] pix;
  } side_t;

  // result of two restoring divide steps
  typedef struct packed {
    logic [1:0] q;
    num_t       rem;
  } step_t;

  // exact floor(x / 255) for x below 255*256
  function automatic chan_t div255(input prod_t x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // two restoring steps at quotient bits sh+1 and sh
  function automatic step_t div2(input num_t rem, input chan_t den, input logic [2:0] sh);
    num_t  r;
    num_t  t;
    step_t s;
    r = rem;
    t = num_t'(den) << (sh + 3'd1);
    s.q[1] = (r >= t);
    if (s.q[1]) begin
      r = r - t;
    end
    t = num_t'(den) << sh;
    s.q[0] = (r >= t);
    if (s.q[0]) begin
      r = r - t;
    end
    s.rem = r;
    return s;
  endfunction

endpackage

// File: rtl/abso_premul.sv
// premultiply stages: channel by alpha products, then rounding divide by 255
module abso_premul (
  input  logic                                        clk,
  input  logic [1:0]                                  en,
  input  logic [abso_pkg::PW-1:0]                     src,
  input  logic [abso_pkg::PW-1:0]                     dst,
  output logic [abso_pkg::NCH-1:0][abso_pkg::CW-1:0]  ps,
  output logic [abso_pkg::NCH-1:0][abso_pkg::CW-1:0]  pd,
  output abso_pkg::chan_t                             inv,
  output abso_pkg::chan_t                             oa
);

  abso_pkg::prod_t [abso_pkg::NCH-1:0] ms1_r, ms1_nxt;
  abso_pkg::prod_t [abso_pkg::NCH-1:0] md1_r, md1_nxt;
  abso_pkg::prod_t                     ma1_r, ma1_nxt;
  abso_pkg::chan_t                     sa1_r, inv1_r, inv1_nxt;

  logic [abso_pkg::NCH-1:0][abso_pkg::CW-1:0] ps2_r, ps2_nxt, pd2_r, pd2_nxt;
  abso_pkg::chan_t                            oa2_r, oa2_nxt, inv2_r;

  // stage one: products with rounding bias
  always_comb begin
    abso_pkg::chan_t sa;
    abso_pkg::chan_t da;
    sa       = src[31:24];
    da       = dst[31:24];
    inv1_nxt = abso_pkg::C_MAX - sa;
    for (int c = 0; c < abso_pkg::NCH; c++) begin
      ms1_nxt[c] = abso_pkg::prod_t'(src[8*c +: 8]) * abso_pkg::prod_t'(sa) + abso_pkg::RND;
      md1_nxt[c] = abso_pkg::prod_t'(dst[8*c +: 8]) * abso_pkg::prod_t'(da) + abso_pkg::RND;
    end
    ma1_nxt = abso_pkg::prod_t'(da) * abso_pkg::prod_t'(inv1_nxt) + abso_pkg::RND;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ms1_r  <= ms1_nxt;
      md1_r  <= md1_nxt;
      ma1_r  <= ma1_nxt;
      sa1_r  <= src[31:24];
      inv1_r <= inv1_nxt;
    end
  end

  // stage two: divide by 255, output alpha
  always_comb begin
    for (int c = 0; c < abso_pkg::NCH; c++) begin
      ps2_nxt[c] = abso_pkg::div255(ms1_r[c]);
      pd2_nxt[c] = abso_pkg::div255(md1_r[c]);
    end
    oa2_nxt = sa1_r + abso_pkg::div255(ma1_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ps2_r  <= ps2_nxt;
      pd2_r  <= pd2_nxt;
      oa2_r  <= oa2_nxt;
      inv2_r <= inv1_r;
    end
  end

  assign ps  = ps2_r;
  assign pd  = pd2_r;
  assign inv = inv2_r;
  assign oa  = oa2_r;

endmodule

// File: rtl/abso_mix.sv
// source-over combine stages: scale destination, add source, build dividend
module abso_mix (
  input  logic                                        clk,
  input  logic [2:0]                                  en,
  input  logic [abso_pkg::NCH-1:0][abso_pkg::CW-1:0]  ps,
  input  logic [abso_pkg::NCH-1:0][abso_pkg::CW-1:0]  pd,
  input  abso_pkg::chan_t                             inv,
  input  abso_pkg::chan_t                             oa,
  output abso_pkg::num_t [abso_pkg::NCH-1:0]          num,
  output logic [abso_pkg::NCH-1:0]                    sat,
  output abso_pkg::chan_t                             oa_out
);

  abso_pkg::prod_t [abso_pkg::NCH-1:0]        mp3_r, mp3_nxt;
  logic [abso_pkg::NCH-1:0][abso_pkg::CW-1:0] ps3_r;
  abso_pkg::chan_t                            oa3_r;

  abso_pkg::sum_t [abso_pkg::NCH-1:0]         p4_r, p4_nxt;
  abso_pkg::chan_t                            oa4_r;

  abso_pkg::num_t [abso_pkg::NCH-1:0]         n5_r, n5_nxt;
  logic [abso_pkg::NCH-1:0]                   sat5_r, sat5_nxt;
  abso_pkg::chan_t                            oa5_r;

  // stage three: destination premultiplied color times (255 - source alpha)
  always_comb begin
    for (int c = 0; c < abso_pkg::NCH; c++) begin
      mp3_nxt[c] = abso_pkg::prod_t'(pd[c]) * abso_pkg::prod_t'(inv) + abso_pkg::RND;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mp3_r <= mp3_nxt;
      ps3_r <= ps;
      oa3_r <= oa;
    end
  end

  // stage four: premultiplied result color
  always_comb begin
    for (int c = 0; c < abso_pkg::NCH; c++) begin
      p4_nxt[c] = abso_pkg::sum_t'(ps3_r[c]) + abso_pkg::sum_t'(abso_pkg::div255(mp3_r[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p4_r  <= p4_nxt;
      oa4_r <= oa3_r;
    end
  end

  // stage five: dividend p*255 + oa/2 and saturation check against 256*oa
  always_comb begin
    abso_pkg::num_t pv;
    for (int c = 0; c < abso_pkg::NCH; c++) begin
      pv          = abso_pkg::num_t'(p4_r[c]);
      n5_nxt[c]   = (pv << 8) - pv + abso_pkg::num_t'(oa4_r[7:1]);
      sat5_nxt[c] = (n5_nxt[c] >= (abso_pkg::num_t'(oa4_r) << 8));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      n5_r   <= n5_nxt;
      sat5_r <= sat5_nxt;
      oa5_r  <= oa4_r;
    end
  end

  assign num    = n5_r;
  assign sat    = sat5_r;
  assign oa_out = oa5_r;

endmodule

// File: rtl/abso_udiv.sv
// pipelined restoring divider, two quotient bits per stage, saturating at 255
module abso_udiv (
  input  logic            clk,
  input  logic [2:0]      en,
  input  abso_pkg::num_t  num,
  input  logic            sat,
  input  abso_pkg::chan_t den,
  output abso_pkg::chan_t quo
);

  abso_pkg::num_t  rem_r [0:2];
  abso_pkg::chan_t quo_r [0:2];
  abso_pkg::chan_t den_r [0:2];
  logic            sat_r [0:2];
  abso_pkg::step_t last_nxt;

  // registered stages resolve quotient bits 7..2
  for (genvar j = 0; j < 3; j++) begin : g_stg
    abso_pkg::num_t  rem_in;
    abso_pkg::chan_t quo_in;
    abso_pkg::chan_t den_in;
    logic            sat_in;
    abso_pkg::step_t step_nxt;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign quo_in = '0;
      assign den_in = den;
      assign sat_in = sat;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign den_in = den_r[j-1];
      assign sat_in = sat_r[j-1];
    end

    assign step_nxt = abso_pkg::div2(rem_in, den_in, 3'(6 - 2*j));

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= step_nxt.rem;
        quo_r[j] <= {quo_in[5:0], step_nxt.q};
        den_r[j] <= den_in;
        sat_r[j] <= sat_in;
      end
    end
  end

  // last two bits feed the output register directly
  assign last_nxt = abso_pkg::div2(rem_r[2], den_r[2], 3'd0);
  assign quo      = sat_r[2] ? abso_pkg::C_MAX : {quo_r[2][5:0], last_nxt.q};

endmodule

// File: rtl/alpha_blend_source_over.sv
// top level of the source-over ARGB8888 blender: handshake, bypass and output
//
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+-----------------------
//  in      | in_valid in_ready in_src_pixel in_dst_pixel | in_valid & in_ready
//  out     | out_valid out_ready out_pixel            | out_valid & out_ready
//  cfg     | cfg_valid cfg_ready cfg_compose_mode     | cfg_valid & cfg_ready
//
// one pixel pair per clock while the output is not stalled
// the depth is the input register, two premultiply stages, three combine stages,
// three divide-by-output-alpha stages and the output register
// reset clears all stage valid bits and selects source-over blending
// each stage holds while the stage after it is full and stalled; empty stages
// keep filling, so in_ready drops only when all ten stages hold a pixel
module alpha_blend_source_over (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [abso_pkg::PW-1:0] in_src_pixel,
  input  logic [abso_pkg::PW-1:0] in_dst_pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [abso_pkg::PW-1:0] out_pixel,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_compose_mode
);

  logic                    mode_r;
  logic [abso_pkg::NSTG-1:0] v_r, v_nxt, en;

  logic [abso_pkg::PW-1:0] src0_r, dst0_r;
  logic                    mode0_r;

  abso_pkg::side_t sb_r [abso_pkg::S_PRE:abso_pkg::S_OUT-1];
  abso_pkg::side_t sb1_nxt;
  abso_pkg::chan_t oa_r [abso_pkg::S_DIV:abso_pkg::S_OUT-1];

  logic [abso_pkg::NCH-1:0][abso_pkg::CW-1:0] ps, pd;
  abso_pkg::chan_t                            inv, oa_pre, oa_mix;
  abso_pkg::num_t [abso_pkg::NCH-1:0]         num;
  logic [abso_pkg::NCH-1:0]                   sat;
  abso_pkg::chan_t                            quo [abso_pkg::NCH];

  logic [abso_pkg::PW-1:0] out_pix_r, out_pix_nxt;

  // mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= abso_pkg::MODE_OVER;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_compose_mode;
    end
  end

  // stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[abso_pkg::NSTG-1] = !v_r[abso_pkg::NSTG-1] || out_ready;
    for (int i = abso_pkg::NSTG-2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < abso_pkg::NSTG; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[abso_pkg::S_OUT];
  assign out_pixel = out_pix_r;

  // input register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      src0_r  <= in_src_pixel;
      dst0_r  <= in_dst_pixel;
      mode0_r <= mode_r;
    end
  end

  // bypass cases: copy mode, transparent or opaque source
  always_comb begin
    sb1_nxt.byp = (mode0_r == abso_pkg::MODE_COPY) || (src0_r[31:24] == abso_pkg::A_CLEAR) ||
                  (src0_r[31:24] == abso_pkg::A_OPAQUE);
    sb1_nxt.pix = ((mode0_r == abso_pkg::MODE_COPY) || (src0_r[31:24] == abso_pkg::A_OPAQUE))
                  ? src0_r : dst0_r;
  end

  // bypass sideband follows the item through the pipeline
  always_ff @(posedge clk) begin
    if (en[abso_pkg::S_PRE]) begin
      sb_r[abso_pkg::S_PRE] <= sb1_nxt;
    end
    for (int i = abso_pkg::S_PRE + 1; i < abso_pkg::S_OUT; i++) begin
      if (en[i]) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // output alpha alongside the divider
  always_ff @(posedge clk) begin
    if (en[abso_pkg::S_DIV]) begin
      oa_r[abso_pkg::S_DIV] <= oa_mix;
    end
    for (int i = abso_pkg::S_DIV + 1; i < abso_pkg::S_OUT; i++) begin
      if (en[i]) begin
        oa_r[i] <= oa_r[i-1];
      end
    end
  end

  abso_premul u_premul (
    .clk (clk),
    .en  (en[abso_pkg::S_PRE +: 2]),
    .src (src0_r),
    .dst (dst0_r),
    .ps  (ps),
    .pd  (pd),
    .inv (inv),
    .oa  (oa_pre)
  );

  abso_mix u_mix (
    .clk    (clk),
    .en     (en[abso_pkg::S_MIX +: 3]),
    .ps     (ps),
    .pd     (pd),
    .inv    (inv),
    .oa     (oa_pre),
    .num    (num),
    .sat    (sat),
    .oa_out (oa_mix)
  );

  for (genvar c = 0; c < abso_pkg::NCH; c++) begin : g_div
    abso_udiv u_udiv (
      .clk (clk),
      .en  (en[abso_pkg::S_DIV +: 3]),
      .num (num[c]),
      .sat (sat[c]),
      .den (oa_mix),
      .quo (quo[c])
    );
  end

  // output register: bypass pixel or un-premultiplied result
  always_comb begin
    if (sb_r[abso_pkg::S_OUT-1].byp) begin
      out_pix_nxt = sb_r[abso_pkg::S_OUT-1].pix;
    end else begin
      out_pix_nxt = {oa_r[abso_pkg::S_OUT-1], quo[2], quo[1], quo[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[abso_pkg::S_OUT]) begin
      out_pix_r <= out_pix_nxt;
    end
  end

endmodule

// File: rtl/abso_chk.sv
// port-level checker for the source-over blender, bound to the top level
module abso_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [abso_pkg::PW-1:0] out_pixel
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel))
    else $error("out_pixel changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // input side can only block when the output is full and stalled
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("in_ready low while output drains");

  // backpressure at the input traces back to a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

endmodule

bind alpha_blend_source_over abso_chk u_abso_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_pixel (out_pixel)
);

// File: tb/tb.sv
// self-checking testbench for the source-over ARGB8888 blender
module tb;
  import abso_pkg::*;

  localparam int LATENCY        = 10;
  localparam int WATCHDOG_LIMIT = 400;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [PW-1:0] in_src_pixel;
  logic [PW-1:0] in_dst_pixel;
  logic          out_valid;
  logic          out_ready;
  logic [PW-1:0] out_pixel;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_compose_mode;

  // no idling on either side when set
  bit calm;
  int idle_cycles;

  // expected pixels in transfer order, with its own copy of the mode
  class pixel_scoreboard;
    logic [PW-1:0] pending_pixels[$];
    logic          mode;
    int            errors;

    function new();
      mode   = MODE_OVER;
      errors = 0;
    endfunction

    // (c*a + 127) / 255
    function int unsigned blend_mul(input int unsigned c, input int unsigned a);
      return (c * a + 127) / 255;
    endfunction

    function logic [PW-1:0] composite(input logic [PW-1:0] src, input logic [PW-1:0] dst);
      int unsigned   sa, da, inv, oa, ps, pd, p, v;
      logic [PW-1:0] res;
      sa = src[PW-1 -: CW];
      da = dst[PW-1 -: CW];
      if (sa == A_CLEAR) return dst;
      if (sa == A_OPAQUE) return src;
      inv = 255 - sa;
      oa  = sa + blend_mul(da, inv);
      // zero output alpha cannot happen here, keep the guard anyway
      if (oa == 0) return dst;
      res = '0;
      res[PW-1 -: CW] = oa[CW-1:0];
      for (int ch = 0; ch < NCH; ch++) begin
        ps = blend_mul(src[ch*CW +: CW], sa);
        pd = blend_mul(dst[ch*CW +: CW], da);
        p  = ps + blend_mul(pd, inv);
        // un-premultiply with round to nearest, saturate
        v  = (p * 255 + oa / 2) / oa;
        res[ch*CW +: CW] = (v > 255) ? C_MAX : v[CW-1:0];
      end
      return res;
    endfunction

    function void note_input(input logic [PW-1:0] src, input logic [PW-1:0] dst);
      logic [PW-1:0] want;
      want           = (mode == MODE_COPY) ? src : composite(src, dst);
      pending_pixels = {pending_pixels, want};
    endfunction

    function void check_result(input logic [PW-1:0] actual);
      logic [PW-1:0] want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected out_pixel, expected none, actual %08h", $time, actual);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (actual !== want) begin
        $display("%0t: out_pixel mismatch, expected %08h, actual %08h", $time, want, actual);
        errors++;
      end
    endfunction
  endclass

  pixel_scoreboard sb;

  alpha_blend_source_over u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_src_pixel     (in_src_pixel),
    .in_dst_pixel     (in_dst_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel        (out_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_compose_mode (cfg_compose_mode)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_src_pixel, in_dst_pixel);
    if (rst_n && out_valid && out_ready) sb.check_result(out_pixel);
    if (rst_n && cfg_valid && cfg_ready) sb.mode = cfg_compose_mode;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver with random stall bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // one pixel pair transfer, with an occasional gap before it
  task automatic send_pixel(input logic [PW-1:0] src, input logic [PW-1:0] dst);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_src_pixel <= src;
    in_dst_pixel <= dst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait for every expected pixel
  task automatic drain_results();
    in_valid <= 1'b0;
    // let the monitor note the last input transfer first
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid        <= 1'b1;
    cfg_compose_mode <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // alphas lean toward the edges of the blend path, colors toward extremes
  function automatic logic [PW-1:0] rand_pixel();
    logic [CW-1:0] a;
    logic [23:0]   rgb;
    case ($urandom_range(0, 9))
      0:       a = A_CLEAR;
      1:       a = A_OPAQUE;
      2:       a = 8'd1;
      3:       a = 8'd254;
      default: a = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       rgb = 24'h000000;
      1:       rgb = 24'hFFFFFF;
      default: rgb = 24'($urandom);
    endcase
    return {a, rgb};
  endfunction

  initial begin
    sb               = new();
    calm             = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_src_pixel     = '0;
    in_dst_pixel     = '0;
    cfg_valid        = 1'b0;
    cfg_compose_mode = MODE_OVER;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed blending after reset (source-over by default)
    // clear source passes the destination
    send_pixel(32'h00000000, 32'hFFFFFFFF);
    send_pixel(32'h00FFFFFF, 32'h12345678);
    // opaque source passes the source
    send_pixel(32'hFFFFFFFF, 32'h00000000);
    send_pixel(32'hFF000000, 32'hFFFFFFFF);
    // alpha just above clear and just below opaque
    send_pixel(32'h01FFFFFF, 32'h00000000);
    send_pixel(32'h01000000, 32'hFF000000);
    send_pixel(32'hFEFFFFFF, 32'hFFFFFFFF);
    send_pixel(32'hFE00FF00, 32'hFE00FF00);
    // rounding pushes channels toward saturation
    send_pixel(32'h01FF00FF, 32'h00FF00FF);
    send_pixel(32'h80FFFFFF, 32'h01FFFFFF);
    send_pixel(32'h02FFFFFF, 32'h01FFFFFF);
    send_pixel(32'h7F808080, 32'h80FF00FF);
    send_pixel(32'h80000000, 32'h00FFFFFF);
    send_pixel(32'h55AA55AA, 32'hAA55AA55);
    send_pixel(32'hFE000000, 32'h00FFFFFF);
    send_pixel(32'h01123456, 32'hFFFFFFFF);
    drain_results();

    // directed copy mode
    write_mode(MODE_COPY);
    send_pixel(32'h00000000, 32'hFFFFFFFF);
    send_pixel(32'h80ABCDEF, 32'h12345678);
    send_pixel(32'hFFFFFFFF, 32'h00000000);
    send_pixel(32'h01FFFFFF, 32'hFF000000);
    drain_results();

    // random phases with both mode settings, the last one without idling
    for (int ph = 0; ph < 6; ph++) begin
      write_mode((ph == 1 || ph == 4) ? MODE_COPY : MODE_OVER);
      calm = (ph == 5);
      repeat ((ph == 1 || ph == 4) ? 100 : ((ph == 5) ? 350 : 300)) begin
        send_pixel(rand_pixel(), rand_pixel());
      end
      drain_results();
    end

    // let any stray output show up
    repeat (3 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
